FILE: rtl/lrw_pkg.sv
// Shared types, constants and LFSR helper functions of the random offset walker.
package lrw_pkg;

  // Field widths
  localparam int BASE_W   = 48;
  localparam int AREA_W   = 48;
  localparam int LEN_W    = 32;
  localparam int OFF_W    = 49;
  localparam int POS_W    = 16;
  localparam int CNT_W    = 16;
  localparam int STRIDE_W = 48;
  localparam int CSTR_W   = 32;
  localparam int WIDTH_W  = 5;
  localparam int CIDX_W   = 2;
  localparam int CDAT_W   = 32;

  // LFSR seed that splices the zero state into the cycle, and the narrowest LFSR
  localparam logic [15:0]        SEED     = 16'hace1;
  localparam logic [WIDTH_W-1:0] MIN_BITS = 5'd8;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FILL_MODE    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_STRIDE_BYTES = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_OVER    = 2'd2,
    ST_NO_WALK = 2'd3
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    capture;
    logic    clear_active;
    logic    div_first;
    logic    div_second;
    logic    load_fill_stride;
    logic    load_reg_walk;
    logic    setup;
    logic    step_init;
    logic    step;
    logic    mul_lo;
    logic    mul_hi;
    logic    out_load;
    status_t out_status;
  } lrw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mode;
    logic fill_mode;
    logic len_bad;
    logic blk_over;
    logic quo_over;
    logic div_done;
    logic walk_active;
    logic count_zero;
    logic step_done;
    logic out_busy;
  } lrw_stat_t;

  // One Fibonacci LFSR step at the given width, with zero spliced in after the seed
  function automatic logic [15:0] lfsr_next(input logic [15:0] v,
                                            input logic [WIDTH_W-1:0] bits);
    logic [15:0] mask;
    logic [15:0] seed;
    logic [15:0] vv;
    logic [15:0] res;
    logic        fb;
    for (int i = 0; i < 16; i++) begin
      mask[i] = (5'(i) < bits);
    end
    seed = mask & SEED;
    vv   = v & mask;
    if (vv == seed) begin
      res = '0;
    end else begin
      if (vv == '0) begin
        vv = seed;
      end
      case (bits)
        5'd8:    fb = vv[0] ^ vv[2] ^ vv[3] ^ vv[4];
        5'd9:    fb = vv[0] ^ vv[4];
        5'd10:   fb = vv[0] ^ vv[3];
        5'd11:   fb = vv[0] ^ vv[2];
        5'd12:   fb = vv[0] ^ vv[1] ^ vv[2] ^ vv[8];
        5'd13:   fb = vv[0] ^ vv[1] ^ vv[2] ^ vv[5];
        5'd14:   fb = vv[0] ^ vv[1] ^ vv[2] ^ vv[12];
        5'd15:   fb = vv[0] ^ vv[1];
        default: fb = vv[0] ^ vv[2] ^ vv[3] ^ vv[5];
      endcase
      res = vv >> 1;
      res[4'(bits - 5'd1)] = fb;
      res = res & mask;
    end
    return res;
  endfunction

  // Bit length of a count, never below the narrowest LFSR
  function automatic logic [WIDTH_W-1:0] bit_len(input logic [CNT_W-1:0] c);
    logic [WIDTH_W-1:0] n;
    n = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (c[i]) begin
        n = 5'(i + 1);
      end
    end
    if (n < MIN_BITS) begin
      n = MIN_BITS;
    end
    return n;
  endfunction

endpackage

FILE: rtl/lrw_div.sv
// Restoring divider, one quotient bit per cycle, shared by both fill mode divisions.
module lrw_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lrw_pkg::AREA_W-1:0]   dividend,
  input  logic [lrw_pkg::LEN_W-1:0]    divisor,
  output logic                         done,
  output logic [lrw_pkg::AREA_W-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(lrw_pkg::AREA_W);
  localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(lrw_pkg::AREA_W - 1);

  logic                        busy;
  logic [CNT_BITS-1:0]         cnt;
  logic [lrw_pkg::LEN_W:0]     rem;
  logic [lrw_pkg::LEN_W-1:0]   dsr;
  logic [lrw_pkg::AREA_W-1:0]  quo;
  logic [lrw_pkg::LEN_W:0]     rem_sh;
  logic                        fits;

  // Shift in the next dividend bit and trial subtract
  assign rem_sh = {rem[lrw_pkg::LEN_W-1:0], quo[lrw_pkg::AREA_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr});

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_BIT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
      quo <= {quo[lrw_pkg::AREA_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/lrw_datapath.sv
// Datapath: configuration, walk state, LFSR, divider, offset multiply and output register.
module lrw_datapath #(
  parameter int MAX_LFSR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [lrw_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [lrw_pkg::CDAT_W-1:0]    cfg_data,
  // input item fields
  input  logic                          in_mode,
  input  logic [lrw_pkg::BASE_W-1:0]    in_base_offset,
  input  logic [lrw_pkg::AREA_W-1:0]    in_area_size,
  input  logic [lrw_pkg::LEN_W-1:0]     in_chunk_len,
  // controller link
  input  lrw_pkg::lrw_cmd_t             cmd,
  output lrw_pkg::lrw_stat_t            stat,
  // result item
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lrw_pkg::OFF_W-1:0]     out_offset,
  output logic [lrw_pkg::POS_W-1:0]     out_position,
  output logic                          out_last,
  output lrw_pkg::status_t              out_status
);

  localparam logic [lrw_pkg::AREA_W-1:0] COUNT_LIMIT =
    lrw_pkg::AREA_W'((64'd1 << MAX_LFSR_BITS) - 64'd1);
  localparam logic [MAX_LFSR_BITS:0] GUARD_LIMIT = {1'b1, {MAX_LFSR_BITS{1'b0}}};

  // Configuration registers
  logic                          fill_mode;
  logic [lrw_pkg::CSTR_W-1:0]    stride_bytes;
  logic [lrw_pkg::CNT_W-1:0]     block_count;

  // Latched input item
  logic                          item_mode;
  logic [lrw_pkg::BASE_W-1:0]    item_base;
  logic [lrw_pkg::AREA_W-1:0]    item_area;
  logic [lrw_pkg::LEN_W-1:0]     item_len;

  // Walk state
  logic [MAX_LFSR_BITS-1:0]      lfsr_value;
  logic [lrw_pkg::WIDTH_W-1:0]   lfsr_width;
  logic [lrw_pkg::CNT_W-1:0]     walk_count;
  logic [lrw_pkg::CNT_W-1:0]     emitted_count;
  logic [lrw_pkg::STRIDE_W-1:0]  walk_stride;
  logic [lrw_pkg::BASE_W-1:0]    walk_base;
  logic                          walk_active;
  logic [MAX_LFSR_BITS:0]        guard;

  // Offset accumulator
  logic [lrw_pkg::OFF_W-1:0]     acc;
  logic                          last_flag;

  // Divider link
  logic                          div_start;
  logic [lrw_pkg::LEN_W-1:0]     div_divisor;
  logic                          div_done;
  logic [lrw_pkg::AREA_W-1:0]    quotient;

  logic [15:0]                   lfsr_nxt;
  logic [lrw_pkg::POS_W-1:0]     pos;
  logic [47:0]                   prod_lo;
  logic [31:0]                   prod_hi;

  // Select divisor: chunk length first, then the first quotient (the walk count)
  assign div_start   = cmd.div_first | cmd.div_second;
  assign div_divisor = cmd.div_second ? lrw_pkg::LEN_W'(quotient[lrw_pkg::CNT_W-1:0])
                                      : item_len;

  lrw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (item_area),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next LFSR state and the two partial products of the offset
  assign lfsr_nxt = lrw_pkg::lfsr_next(16'(lfsr_value), lfsr_width);
  assign pos      = 16'(lfsr_value);
  assign prod_lo  = 48'(pos) * 48'(walk_stride[31:0]);
  assign prod_hi  = 32'(pos) * 32'(walk_stride[47:32]);

  // Status to the controller
  assign stat.mode        = item_mode;
  assign stat.fill_mode   = fill_mode;
  assign stat.len_bad     = (item_len == '0) || (item_area < lrw_pkg::AREA_W'(item_len));
  assign stat.blk_over    = lrw_pkg::AREA_W'(block_count) > COUNT_LIMIT;
  assign stat.quo_over    = quotient > COUNT_LIMIT;
  assign stat.div_done    = div_done;
  assign stat.walk_active = walk_active;
  assign stat.count_zero  = (walk_count == '0);
  assign stat.step_done   = (lfsr_nxt < walk_count) || (guard == GUARD_LIMIT);
  assign stat.out_busy    = out_valid & ~out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode    <= 1'b0;
      stride_bytes <= '0;
      block_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrw_pkg::CFG_FILL_MODE:    fill_mode    <= cfg_data[0];
        lrw_pkg::CFG_STRIDE_BYTES: stride_bytes <= cfg_data;
        lrw_pkg::CFG_BLOCK_COUNT:  block_count  <= cfg_data[lrw_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= in_mode;
      item_base <= in_base_offset;
      item_area <= in_area_size;
      item_len  <= in_chunk_len;
    end
  end

  // Walk state: set up, step the LFSR, count emitted items
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_value    <= '0;
      lfsr_width    <= lrw_pkg::MIN_BITS;
      walk_count    <= '0;
      emitted_count <= '0;
      walk_stride   <= '0;
      walk_base     <= '0;
      walk_active   <= 1'b0;
      guard         <= '0;
    end else begin
      if (cmd.clear_active) begin
        walk_active <= 1'b0;
      end
      if (cmd.load_reg_walk) begin
        walk_count  <= block_count;
        walk_stride <= lrw_pkg::STRIDE_W'(stride_bytes);
      end
      if (cmd.div_second) begin
        walk_count <= quotient[lrw_pkg::CNT_W-1:0];
      end
      if (cmd.load_fill_stride) begin
        walk_stride <= quotient;
      end
      if (cmd.setup) begin
        lfsr_width    <= lrw_pkg::bit_len(walk_count);
        lfsr_value    <= '0;
        emitted_count <= '0;
        walk_base     <= item_base;
        walk_active   <= (walk_count != '0);
      end
      if (cmd.step_init) begin
        guard <= '0;
      end
      if (cmd.step) begin
        lfsr_value <= lfsr_nxt[MAX_LFSR_BITS-1:0];
        guard      <= guard + 1'b1;
        if (stat.step_done) begin
          emitted_count <= emitted_count + 1'b1;
        end
      end
      if (cmd.mul_lo && (emitted_count >= walk_count)) begin
        walk_active <= 1'b0;
      end
    end
  end

  // Offset: base plus low partial product, then the high partial product
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      acc       <= lrw_pkg::OFF_W'(walk_base) + lrw_pkg::OFF_W'(prod_lo);
      last_flag <= (emitted_count >= walk_count);
    end else if (cmd.mul_hi) begin
      acc <= acc + {prod_hi[lrw_pkg::OFF_W-33:0], 32'd0};
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; error results carry zero fields
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      if (cmd.out_status == lrw_pkg::ST_OK) begin
        out_offset   <= acc;
        out_position <= pos;
        out_last     <= last_flag;
      end else begin
        out_offset   <= '0;
        out_position <= '0;
        out_last     <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/lrw_ctrl.sv
// Controller: sequences start, divide, LFSR search, multiply and output per item.
module lrw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lrw_pkg::lrw_stat_t  stat,
  output lrw_pkg::lrw_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV1,
    S_DIV2,
    S_SETUP,
    S_STEP,
    S_MUL_LO,
    S_MUL_HI,
    S_OUT
  } state_t;

  state_t           state;
  state_t           state_next;
  lrw_pkg::status_t res_status;
  lrw_pkg::status_t res_status_next;

  assign in_ready = (state == S_IDLE);

  // Decode commands and the next state
  always_comb begin
    cmd             = '0;
    cmd.out_status  = res_status;
    state_next      = state;
    res_status_next = res_status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.mode) begin
          if (!stat.walk_active) begin
            res_status_next = lrw_pkg::ST_NO_WALK;
            state_next      = S_OUT;
          end else begin
            cmd.step_init = 1'b1;
            state_next    = S_STEP;
          end
        end else begin
          cmd.clear_active = 1'b1;
          if (stat.fill_mode) begin
            if (stat.len_bad) begin
              res_status_next = lrw_pkg::ST_BAD_LEN;
              state_next      = S_OUT;
            end else begin
              cmd.div_first = 1'b1;
              state_next    = S_DIV1;
            end
          end else if (stat.blk_over) begin
            res_status_next = lrw_pkg::ST_OVER;
            state_next      = S_OUT;
          end else begin
            cmd.load_reg_walk = 1'b1;
            state_next        = S_SETUP;
          end
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          if (stat.quo_over) begin
            res_status_next = lrw_pkg::ST_OVER;
            state_next      = S_OUT;
          end else begin
            cmd.div_second = 1'b1;
            state_next     = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (stat.div_done) begin
          cmd.load_fill_stride = 1'b1;
          state_next           = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (stat.count_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.step_init = 1'b1;
          state_next    = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.step_done) begin
          res_status_next = lrw_pkg::ST_OK;
          state_next      = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the pending result status
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= lrw_pkg::ST_OK;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

FILE: rtl/lfsr_random_offset_walker.sv
// Top level of the LFSR random offset walker: controller plus datapath.
//
// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      s_tdata: base_offset, area_size, chunk_len; s_tuser: mode
// m_*      out  m_tvalid / m_tready      m_tdata: offset, position; m_tlast: last; m_tuser: status
// cfg_*    in   cfg_valid / cfg_ready    cfg_index: register index; cfg_data: value
//
// A next item runs the LFSR search, then the low and high multiply steps and
// the output load; the LFSR search advances one state per cycle. A start item
// with register count/stride first sets up the walk; in fill mode the shared
// one-bit-per-cycle divider adds two divisions before the set-up. Reset is
// synchronous and clears all control state; there is no clearing pass. A stalled
// result waits in the output register while the next item is taken; the block
// stalls only if that item's result is ready before the previous one leaves.
module lfsr_random_offset_walker #(
  parameter int MAX_LFSR_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [127:0]                s_tdata,   // [47:0] base_offset, [95:48] area_size,
                                                 // [127:96] chunk_len
  input  logic                        s_tuser,   // [0] mode
  // result items
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [71:0]                 m_tdata,   // [48:0] offset, [64:49] position,
                                                 // [71:65] zero
  output logic                        m_tlast,   // last
  output logic [1:0]                  m_tuser,   // [1:0] status
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lrw_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lrw_pkg::CDAT_W-1:0]  cfg_data
);

  lrw_pkg::lrw_cmd_t   cmd;
  lrw_pkg::lrw_stat_t  stat;
  logic [lrw_pkg::OFF_W-1:0] out_offset;
  logic [lrw_pkg::POS_W-1:0] out_position;
  lrw_pkg::status_t          out_status;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  lrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrw_datapath #(
    .MAX_LFSR_BITS (MAX_LFSR_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mode        (s_tuser),
    .in_base_offset (s_tdata[47:0]),
    .in_area_size   (s_tdata[95:48]),
    .in_chunk_len   (s_tdata[127:96]),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_offset     (out_offset),
    .out_position   (out_position),
    .out_last       (m_tlast),
    .out_status     (out_status)
  );

  // Pack the result item
  assign m_tdata = {7'd0, out_position, out_offset};
  assign m_tuser = out_status;

endmodule
